### hdl/ldn_pkg.sv
// shared constants, types and mask weights of the directional code unit
package ldn_pkg;

    // window and direction geometry
    localparam int NUM_DIRS = 8;
    localparam int PIX_BITS = 8;
    localparam int DIR_W    = $clog2(NUM_DIRS);
    localparam int CODE_W   = 2 * DIR_W;
    localparam int HALF     = NUM_DIRS / 2;
    localparam int PAIRS    = NUM_DIRS / 2;

    // q24 gaussian-derivative weights
    localparam int GA_WEIGHT = 11863283;
    localparam int GB_WEIGHT = 44;
    localparam int GA_BITS   = 24;

    // signed response width: |ga * diff| plus the small gb term stays below 2^(24 + PIX_BITS)
    localparam int RESP_W = PIX_BITS + GA_BITS + 1;

    // mask selection codes
    localparam logic MODE_KIRSCH = 1'b0;
    localparam logic MODE_GAUSS  = 1'b1;

    typedef logic [PIX_BITS-1:0]      pix_t;
    typedef pix_t [NUM_DIRS-1:0]      ring_t;
    typedef logic signed [RESP_W-1:0] resp_t;
    typedef resp_t [NUM_DIRS-1:0]     resp_vec_t;
    typedef logic [DIR_W-1:0]         dir_t;
    typedef logic [CODE_W-1:0]        code_t;

    // one beat of lane responses handed to the merge stage
    typedef struct packed {
        logic      valid;
        resp_vec_t resp;
    } lane_beat_t;

endpackage

### hdl/ldn_dir_lane.sv
// one direction lane: mask response of the ring rotated to its direction
module ldn_dir_lane (
    input  logic          clk,
    input  logic          mode,
    input  ldn_pkg::ring_t ring,
    output ldn_pkg::resp_t resp
);

    localparam ldn_pkg::resp_t GA_W = ldn_pkg::resp_t'(ldn_pkg::GA_WEIGHT);
    localparam ldn_pkg::resp_t GB_W = ldn_pkg::resp_t'(ldn_pkg::GB_WEIGHT);

    logic [ldn_pkg::PIX_BITS+1:0]        pos_sum;
    logic [ldn_pkg::PIX_BITS+2:0]        ring_sum;
    ldn_pkg::resp_t                      kirsch_resp;
    logic signed [ldn_pkg::PIX_BITS:0]   diff_a;
    logic signed [ldn_pkg::PIX_BITS+2:0] diff_b;
    ldn_pkg::resp_t                      prod_a;
    ldn_pkg::resp_t                      prod_b;
    ldn_pkg::resp_t                      resp_next;
    ldn_pkg::resp_t                      resp_reg;

    // kirsch: 5 * front three - 3 * back five == 8 * front - 3 * whole ring
    always_comb
    begin
        pos_sum = {2'b00, ring[ldn_pkg::NUM_DIRS-1]} + {2'b00, ring[0]} + {2'b00, ring[1]};
        ring_sum = '0;
        for (int k = 0; k < ldn_pkg::NUM_DIRS; k++)
        begin
            ring_sum = ring_sum + {3'b000, ring[k]};
        end
        kirsch_resp = ldn_pkg::resp_t'({pos_sum, 3'b000})
                    - (ldn_pkg::resp_t'(ring_sum) + ldn_pkg::resp_t'({ring_sum, 1'b0}));
    end

    // gaussian derivative: ga across the axis, gb on the flanking taps
    always_comb
    begin
        diff_a = signed'({1'b0, ring[ldn_pkg::HALF]}) - signed'({1'b0, ring[0]});
        diff_b = signed'({3'b000, ring[ldn_pkg::HALF-1]})
               + signed'({3'b000, ring[ldn_pkg::HALF+1]})
               - signed'({3'b000, ring[1]})
               - signed'({3'b000, ring[ldn_pkg::NUM_DIRS-1]});
        prod_a = ldn_pkg::resp_t'(diff_a) * GA_W;
        prod_b = ldn_pkg::resp_t'(diff_b) * GB_W;
    end

    // mask family select
    always_comb
    begin
        unique case (mode)
            ldn_pkg::MODE_GAUSS:  resp_next = prod_a + prod_b;
            ldn_pkg::MODE_KIRSCH: resp_next = kirsch_resp;
            default:              resp_next = kirsch_resp;
        endcase
    end

    // response register
    always_ff @(posedge clk)
    begin
        resp_reg <= resp_next;
    end

    assign resp = resp_reg;

endmodule

### hdl/ldn_merge.sv
// merge stage: registered tree search for the largest and smallest response
module ldn_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  ldn_pkg::lane_beat_t lanes,
    output logic                done,
    output ldn_pkg::code_t      dir_code
);

    ldn_pkg::resp_t hi_val_next [ldn_pkg::PAIRS];
    ldn_pkg::resp_t lo_val_next [ldn_pkg::PAIRS];
    ldn_pkg::dir_t  hi_idx_next [ldn_pkg::PAIRS];
    ldn_pkg::dir_t  lo_idx_next [ldn_pkg::PAIRS];
    ldn_pkg::resp_t hi_val_reg  [ldn_pkg::PAIRS];
    ldn_pkg::resp_t lo_val_reg  [ldn_pkg::PAIRS];
    ldn_pkg::dir_t  hi_idx_reg  [ldn_pkg::PAIRS];
    ldn_pkg::dir_t  lo_idx_reg  [ldn_pkg::PAIRS];
    logic           lvl_valid_reg;

    ldn_pkg::resp_t hi_mid_val [2];
    ldn_pkg::resp_t lo_mid_val [2];
    ldn_pkg::dir_t  hi_mid_idx [2];
    ldn_pkg::dir_t  lo_mid_idx [2];
    ldn_pkg::resp_t hi_fin_val;
    ldn_pkg::resp_t lo_fin_val;
    ldn_pkg::dir_t  hi_fin_idx;
    ldn_pkg::dir_t  lo_fin_idx;
    ldn_pkg::code_t code_next;
    ldn_pkg::code_t code_reg;
    logic           done_reg;

    // first level: neighbor pairs, the lower index keeps ties
    always_comb
    begin
        for (int i = 0; i < ldn_pkg::PAIRS; i++)
        begin
            if ($signed(lanes.resp[2*i+1]) > $signed(lanes.resp[2*i]))
            begin
                hi_val_next[i] = lanes.resp[2*i+1];
                hi_idx_next[i] = ldn_pkg::DIR_W'(2*i+1);
            end
            else
            begin
                hi_val_next[i] = lanes.resp[2*i];
                hi_idx_next[i] = ldn_pkg::DIR_W'(2*i);
            end
            if ($signed(lanes.resp[2*i+1]) < $signed(lanes.resp[2*i]))
            begin
                lo_val_next[i] = lanes.resp[2*i+1];
                lo_idx_next[i] = ldn_pkg::DIR_W'(2*i+1);
            end
            else
            begin
                lo_val_next[i] = lanes.resp[2*i];
                lo_idx_next[i] = ldn_pkg::DIR_W'(2*i);
            end
        end
    end

    // first level registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ldn_pkg::PAIRS; i++)
        begin
            hi_val_reg[i] <= hi_val_next[i];
            lo_val_reg[i] <= lo_val_next[i];
            hi_idx_reg[i] <= hi_idx_next[i];
            lo_idx_reg[i] <= lo_idx_next[i];
        end
    end

    // remaining two levels, again the left side keeps ties
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            if ($signed(hi_val_reg[2*j+1]) > $signed(hi_val_reg[2*j]))
            begin
                hi_mid_val[j] = hi_val_reg[2*j+1];
                hi_mid_idx[j] = hi_idx_reg[2*j+1];
            end
            else
            begin
                hi_mid_val[j] = hi_val_reg[2*j];
                hi_mid_idx[j] = hi_idx_reg[2*j];
            end
            if ($signed(lo_val_reg[2*j+1]) < $signed(lo_val_reg[2*j]))
            begin
                lo_mid_val[j] = lo_val_reg[2*j+1];
                lo_mid_idx[j] = lo_idx_reg[2*j+1];
            end
            else
            begin
                lo_mid_val[j] = lo_val_reg[2*j];
                lo_mid_idx[j] = lo_idx_reg[2*j];
            end
        end
        if ($signed(hi_mid_val[1]) > $signed(hi_mid_val[0]))
        begin
            hi_fin_val = hi_mid_val[1];
            hi_fin_idx = hi_mid_idx[1];
        end
        else
        begin
            hi_fin_val = hi_mid_val[0];
            hi_fin_idx = hi_mid_idx[0];
        end
        if ($signed(lo_mid_val[1]) < $signed(lo_mid_val[0]))
        begin
            lo_fin_val = lo_mid_val[1];
            lo_fin_idx = lo_mid_idx[1];
        end
        else
        begin
            lo_fin_val = lo_mid_val[0];
            lo_fin_idx = lo_mid_idx[0];
        end
        code_next = {hi_fin_idx, lo_fin_idx};
    end

    // result register
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    // beat tracking through the two merge levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            lvl_valid_reg <= lanes.valid;
            done_reg      <= lvl_valid_reg;
        end
    end

    assign done     = done_reg;
    assign dir_code = code_reg;

    // winners of pair 0 are ordered
    a_pair0_order: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_valid_reg |-> ($signed(hi_val_reg[0]) >= $signed(lo_val_reg[0])))
        else $error("pair 0 max below min");

    // same direction for max and min only when all responses agree
    a_same_dir_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (lvl_valid_reg && (hi_fin_idx == lo_fin_idx)) |-> (hi_fin_val == lo_fin_val))
        else $error("max and min share a direction with different values");

    // final max never below final min
    a_fin_order: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_valid_reg |-> ($signed(hi_fin_val) >= $signed(lo_fin_val)))
        else $error("final max below final min");

endmodule

### hdl/ldn_directional_code_unit.sv
// top level of the local directional number code unit
//
// usage
//   input beat: pix_nw .. pix_se (one 3x3 window) is taken at a rising edge with
//   start high and busy low; busy is always low, so one window per clock is taken.
//   result beat: dir_code is valid for exactly one cycle while done is high,
//   dir_code = 8 * direction of largest response + direction of smallest response,
//   ties go to the lowest direction (0 east, counterclockwise to 7 southeast).
//   config: cfg_wr_en writes cfg_wr_data into mask_mode (0 kirsch, 1 gaussian);
//   the user must write it only while no window is in flight; the block does not enforce this.
// pipeline and throughput
//   done rises once the window has passed the response registers of the eight lanes
//   (two constant multiplies each in gaussian mode) and the first-level and result
//   registers of the max/min merge tree. one window per clock, fully pipelined.
// reset
//   rst_n clears the beat pipeline and sets mask_mode to kirsch; no result is lost
//   to a stall because the receiver always takes the done beat.
module ldn_directional_code_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  ldn_pkg::pix_t        pix_nw,
    input  ldn_pkg::pix_t        pix_n,
    input  ldn_pkg::pix_t        pix_ne,
    input  ldn_pkg::pix_t        pix_w,
    input  ldn_pkg::pix_t        pix_center,
    input  ldn_pkg::pix_t        pix_e,
    input  ldn_pkg::pix_t        pix_sw,
    input  ldn_pkg::pix_t        pix_s,
    input  ldn_pkg::pix_t        pix_se,
    output logic                 done,
    output logic [5:0]           dir_code
);

    logic                mask_mode_reg;
    logic                lane_valid_reg;
    logic                accept;
    ldn_pkg::ring_t      ring;
    ldn_pkg::resp_vec_t  lane_resp;
    ldn_pkg::lane_beat_t lane_beat;
    ldn_pkg::code_t      merge_code;
    logic                center_unused;

    // pipelined, never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // center tap has zero weight in every mask
    assign center_unused = ^pix_center;

    // ring of neighbors, counterclockwise from east
    assign ring[0] = pix_e;
    assign ring[1] = pix_ne;
    assign ring[2] = pix_n;
    assign ring[3] = pix_nw;
    assign ring[4] = pix_w;
    assign ring[5] = pix_sw;
    assign ring[6] = pix_s;
    assign ring[7] = pix_se;

    // mask mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_mode_reg <= ldn_pkg::MODE_KIRSCH;
        end
        else if (cfg_wr_en)
        begin
            mask_mode_reg <= cfg_wr_data;
        end
    end

    // beat valid alongside the lane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= accept;
        end
    end

    // one lane per direction, each sees the ring rotated to its direction
    for (genvar d = 0; d < ldn_pkg::NUM_DIRS; d++)
    begin : g_lane
        ldn_pkg::ring_t rot;
        for (genvar k = 0; k < ldn_pkg::NUM_DIRS; k++)
        begin : g_tap
            assign rot[k] = ring[(d + k) % ldn_pkg::NUM_DIRS];
        end
        ldn_dir_lane u_lane (
            .clk  (clk),
            .mode (mask_mode_reg),
            .ring (rot),
            .resp (lane_resp[d])
        );
    end

    assign lane_beat.valid = lane_valid_reg;
    assign lane_beat.resp  = lane_resp;

    // max/min merge
    ldn_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .lanes    (lane_beat),
        .done     (done),
        .dir_code (merge_code)
    );

    assign dir_code = merge_code[5:0];

    // every result beat traces back to an accepted window through the lane and merge valid registers
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("result beat without a matching input beat");

endmodule
